[design/slt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types, character codes and state codes for the shell line tokeniser.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int unsigned CharW = 8;

  // Character codes
  localparam logic [CharW-1:0] CH_PIPE = 8'h7C;
  localparam logic [CharW-1:0] CH_LT   = 8'h3C;
  localparam logic [CharW-1:0] CH_GT   = 8'h3E;
  localparam logic [CharW-1:0] CH_AMP  = 8'h26;
  localparam logic [CharW-1:0] CH_SQ   = 8'h27;
  localparam logic [CharW-1:0] CH_DQ   = 8'h22;
  localparam logic [CharW-1:0] CH_SP   = 8'h20;
  localparam logic [CharW-1:0] CH_TAB  = 8'h09;
  localparam logic [CharW-1:0] CH_NL   = 8'h0A;

  // Quote mode codes
  localparam logic [1:0] QM_NONE   = 2'd0;
  localparam logic [1:0] QM_SINGLE = 2'd1;
  localparam logic [1:0] QM_DOUBLE = 2'd2;

  // Token mode codes
  localparam logic [1:0] TM_GAP  = 2'd0;
  localparam logic [1:0] TM_WORD = 2'd1;
  localparam logic [1:0] TM_OP1  = 2'd2;
  localparam logic [1:0] TM_OP2  = 2'd3;

  // Operator indexes
  localparam logic [1:0] OP_PIPE = 2'd0;
  localparam logic [1:0] OP_LT   = 2'd1;
  localparam logic [1:0] OP_GT   = 2'd2;
  localparam logic [1:0] OP_AMP  = 2'd3;

  // Quote error codes
  localparam logic [1:0] QE_OK     = 2'd0;
  localparam logic [1:0] QE_SINGLE = 2'd1;
  localparam logic [1:0] QE_DOUBLE = 2'd2;

  typedef struct packed {
    logic [CharW-1:0] char_out;
    logic             in_token;
    logic             token_start;
    logic             token_kind;
    logic             quoted;
    logic             end_of_line;
    logic [1:0]       quote_error;
  } slt_result_t;

  typedef struct packed {
    logic       is_op;
    logic [1:0] idx;
  } slt_op_t;

  function automatic slt_op_t slt_op_decode(input logic [CharW-1:0] c);
    slt_op_t r;
    r.is_op = 1'b1;
    r.idx   = OP_PIPE;
    case (c)
      CH_PIPE: r.idx = OP_PIPE;
      CH_LT:   r.idx = OP_LT;
      CH_GT:   r.idx = OP_GT;
      CH_AMP:  r.idx = OP_AMP;
      default: r.is_op = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[design/slt_classify.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slt_classify
// Line state and per-byte classification; the state advances on each step.
// ----------------------------------------------------------------------------
module slt_classify (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     step,
  input  wire logic [slt_pkg::CharW-1:0] byte_in,
  input  wire logic                     last_in,
  output slt_pkg::slt_result_t          result
);
  import slt_pkg::*;

  logic [1:0] quote_mode_r, quote_mode_nxt;
  logic [1:0] token_mode_r, token_mode_nxt;
  logic [1:0] open_op_r,    open_op_nxt;
  slt_op_t    op;
  logic       is_space;

  always_comb begin
    op       = slt_op_decode(byte_in);
    is_space = (byte_in == CH_SP) || (byte_in == CH_TAB) || (byte_in == CH_NL);

    quote_mode_nxt     = quote_mode_r;
    token_mode_nxt     = token_mode_r;
    open_op_nxt        = open_op_r;
    result.char_out    = byte_in;
    result.in_token    = 1'b0;
    result.token_start = 1'b0;
    result.token_kind  = 1'b0;
    result.quoted      = 1'b0;
    result.end_of_line = last_in;
    result.quote_error = QE_OK;

    if (quote_mode_r != QM_NONE) begin
      result.in_token = 1'b1;
      result.quoted   = 1'b1;
      if ((quote_mode_r == QM_SINGLE && byte_in == CH_SQ) ||
          (quote_mode_r == QM_DOUBLE && byte_in == CH_DQ)) begin
        quote_mode_nxt = QM_NONE;
      end
      token_mode_nxt = TM_WORD;
    end else if (is_space) begin
      token_mode_nxt = TM_GAP;
    end else if (op.is_op) begin
      result.in_token   = 1'b1;
      result.token_kind = 1'b1;
      // A matching second character completes a two-character operator.
      if (token_mode_r == TM_OP1 && open_op_r == op.idx) begin
        token_mode_nxt = TM_OP2;
      end else begin
        result.token_start = 1'b1;
        token_mode_nxt     = TM_OP1;
        open_op_nxt        = op.idx;
      end
    end else begin
      result.in_token = 1'b1;
      if (token_mode_r != TM_WORD) begin
        result.token_start = 1'b1;
      end
      token_mode_nxt = TM_WORD;
      if (byte_in == CH_SQ) begin
        quote_mode_nxt = QM_SINGLE;
        result.quoted  = 1'b1;
      end else if (byte_in == CH_DQ) begin
        quote_mode_nxt = QM_DOUBLE;
        result.quoted  = 1'b1;
      end
    end

    if (last_in) begin
      case (quote_mode_nxt)
        QM_SINGLE: result.quote_error = QE_SINGLE;
        QM_DOUBLE: result.quote_error = QE_DOUBLE;
        default:   result.quote_error = QE_OK;
      endcase
      quote_mode_nxt = QM_NONE;
      token_mode_nxt = TM_GAP;
      open_op_nxt    = OP_PIPE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_mode_r <= QM_NONE;
      token_mode_r <= TM_GAP;
      open_op_r    <= OP_PIPE;
    end else if (step) begin
      quote_mode_r <= quote_mode_nxt;
      token_mode_r <= token_mode_nxt;
      open_op_r    <= open_op_nxt;
    end
  end

endmodule
`default_nettype wire

[design/shell_line_tokenizer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// shell_line_tokenizer_core
// Classifies a shell command line one byte per transfer.
// ----------------------------------------------------------------------------
// Each accepted byte yields exactly one result, in order. A byte passes
// through an input register and a result register, and its result is offered
// from the result register. The block sustains one byte per clock while
// out_ready is held high:
// the line state (quote mode, token mode, pending operator) updates
// as each byte moves from the input register to the result
// register. in_ready depends combinationally on out_ready. On a byte marked
// last, quote_error reports an unclosed quote and the state returns to its
// reset value for the next line.
// ----------------------------------------------------------------------------
module shell_line_tokenizer_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [slt_pkg::CharW-1:0] in_byte_req,
  input  wire logic                      in_last,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [slt_pkg::CharW-1:0]      out_char_out,
  output logic                           out_in_token,
  output logic                           out_token_start,
  output logic                           out_token_kind,
  output logic                           out_quoted,
  output logic                           out_end_of_line,
  output logic [1:0]                     out_quote_error
);
  import slt_pkg::*;

  logic             s1_valid_r;
  logic [CharW-1:0] s1_byte_r;
  logic             s1_last_r;
  logic             out_valid_r;
  slt_result_t      out_res_r;
  slt_result_t      res;
  logic             out_free;
  logic             s1_move;

  assign out_free = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  slt_classify u_classify (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_move),
    .byte_in (s1_byte_r),
    .last_in (s1_last_r),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte_req;
      s1_last_r <= in_last;
    end
    if (s1_move) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_out    = out_res_r.char_out;
  assign out_in_token    = out_res_r.in_token;
  assign out_token_start = out_res_r.token_start;
  assign out_token_kind  = out_res_r.token_kind;
  assign out_quoted      = out_res_r.quoted;
  assign out_end_of_line = out_res_r.end_of_line;
  assign out_quote_error = out_res_r.quote_error;

endmodule
`default_nettype wire
